@@ rtl/lws_pkg.sv @@
`default_nettype none

package lws_pkg;

    // item and register widths
    localparam int WIN_W  = 25;
    localparam int MODE_W = 3;
    localparam int RING_W = 24;
    localparam int CNT_W  = 4;

    // window side and padded grid side (window plus one outside cell each way)
    localparam int SIDE   = 5;
    localparam int GSIDE  = SIDE + 2;
    localparam int GRID_N = GSIDE * GSIDE;

    // cell (2,2)
    localparam int CENTER_IDX = 12;

    localparam logic [RING_W-1:0] RING_RESET = 24'h0006AE;

    // ring layout
    localparam int RING_TOP  = 0;
    localparam int RING_SIDE = 7;
    localparam int RING_BOT  = 17;

    // boundary modes; codes above MODE_CAPS all use the ring register
    localparam logic [MODE_W-1:0] MODE_DEAD  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ALIVE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SIDES = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CAPS  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RING  = 3'd4;

    typedef logic [GRID_N-1:0]           t_grid;
    typedef logic [WIN_W-1:0][CNT_W-1:0] t_cnt_arr;

endpackage

`default_nettype wire

@@ rtl/lws_if.sv @@
`default_nettype none

interface lws_in_if;
    logic                         valid;
    logic                         ready;
    logic [lws_pkg::WIN_W-1:0]    window_cells;
    logic [lws_pkg::MODE_W-1:0]   boundary_mode;

    modport source (output valid, output window_cells, output boundary_mode, input ready);
    modport sink   (input valid, input window_cells, input boundary_mode, output ready);
endinterface

interface lws_out_if;
    logic                         valid;
    logic                         ready;
    logic [lws_pkg::WIN_W-1:0]    next_cells;
    logic                         center_alive;

    modport source (output valid, output next_cells, output center_alive, input ready);
    modport sink   (input valid, input next_cells, input center_alive, output ready);
endinterface

interface lws_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lws_pkg::RING_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/life_window_step.sv @@
`default_nettype none

// Channel   Dir  Payload                                   Transaction when
// i_win     in   window_cells[24:0], boundary_mode[2:0]    valid & ready
// o_res     out  next_cells[24:0], center_alive            valid & ready
// i_cfg     in   data[23:0] -> boundary ring register      valid & ready (ready tied high)
//
// Three register stages: padded grid, neighbor counts, B3/S23 rule.
// One transaction per cycle sustained while o_res.ready stays high.
// Each stage holds its item while the stage after it is full and stalled; a stage
// that is empty or draining takes a new item, so bubbles are squeezed out.
// i_rst_n is synchronous, active low: clears the stage valid bits and loads the
// ring register with 0x0006AE.

module life_window_step (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lws_in_if.sink    i_win,
    lws_out_if.source o_res,
    lws_cfg_if.sink   i_cfg
);

    // ---------------------------------------------------------------
    // Ring register
    // ---------------------------------------------------------------
    logic [lws_pkg::RING_W-1:0] r_ring;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring <= lws_pkg::RING_RESET;
        end else if (i_cfg.valid) begin
            r_ring <= i_cfg.data;
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a stage can load when empty or when the next one loads
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3      = !r_v3 || o_res.ready;
    assign w_rdy2      = !r_v2 || w_rdy3;
    assign w_rdy1      = !r_v1 || w_rdy2;
    assign i_win.ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_win.valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: 7x7 grid, window in the middle, outside cells from the mode.
    // Grid cell (gx,gy) sits at bit 7*gy+gx; window cell (x,y) at gx=x+1, gy=y+1.
    // ---------------------------------------------------------------
    function automatic logic edge_bit(input logic [lws_pkg::MODE_W-1:0] mode,
                                      input logic [lws_pkg::RING_W-1:0] ring,
                                      input int gx, input int gy);
        logic side;
        int   pos;
        side = (gx == 0) || (gx == lws_pkg::GSIDE - 1);
        if (gy == 0) begin
            pos = lws_pkg::RING_TOP + gx;
        end else if (gy == lws_pkg::GSIDE - 1) begin
            pos = lws_pkg::RING_BOT + gx;
        end else if (gx == 0) begin
            pos = lws_pkg::RING_SIDE + 2 * (gy - 1);
        end else begin
            pos = lws_pkg::RING_SIDE + 1 + 2 * (gy - 1);
        end
        case (mode)
            lws_pkg::MODE_DEAD:  edge_bit = 1'b0;
            lws_pkg::MODE_ALIVE: edge_bit = 1'b1;
            lws_pkg::MODE_SIDES: edge_bit = side;    // corners count as sides
            lws_pkg::MODE_CAPS:  edge_bit = !side;
            default:             edge_bit = ring[pos[4:0]];
        endcase
    endfunction

    lws_pkg::t_grid n_grid, r_grid;

    always_comb begin
        for (int gy = 0; gy < lws_pkg::GSIDE; gy++) begin
            for (int gx = 0; gx < lws_pkg::GSIDE; gx++) begin
                if (gx >= 1 && gx <= lws_pkg::SIDE && gy >= 1 && gy <= lws_pkg::SIDE) begin
                    n_grid[lws_pkg::GSIDE * gy + gx] =
                        i_win.window_cells[lws_pkg::SIDE * (gy - 1) + (gx - 1)];
                end else begin
                    n_grid[lws_pkg::GSIDE * gy + gx] =
                        edge_bit(i_win.boundary_mode, r_ring, gx, gy);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_win.valid) begin
            r_grid <= n_grid;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: eight-neighbor count per window cell, plus its own state
    // ---------------------------------------------------------------
    lws_pkg::t_cnt_arr          n_cnt, r_cnt;
    logic [lws_pkg::WIN_W-1:0]  n_self, r_self;

    always_comb begin
        for (int y = 0; y < lws_pkg::SIDE; y++) begin
            for (int x = 0; x < lws_pkg::SIDE; x++) begin
                n_cnt[lws_pkg::SIDE * y + x] = '0;
                for (int dy = 0; dy < 3; dy++) begin
                    for (int dx = 0; dx < 3; dx++) begin
                        if (dx != 1 || dy != 1) begin
                            n_cnt[lws_pkg::SIDE * y + x] = n_cnt[lws_pkg::SIDE * y + x]
                                + {{(lws_pkg::CNT_W-1){1'b0}},
                                   r_grid[lws_pkg::GSIDE * (y + dy) + (x + dx)]};
                        end
                    end
                end
                n_self[lws_pkg::SIDE * y + x] = r_grid[lws_pkg::GSIDE * (y + 1) + (x + 1)];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_cnt  <= n_cnt;
            r_self <= n_self;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: born on three, survives on two or three; output register
    // ---------------------------------------------------------------
    logic [lws_pkg::WIN_W-1:0] n_next, r_next;

    always_comb begin
        for (int i = 0; i < lws_pkg::WIN_W; i++) begin
            n_next[i] = (r_cnt[i] == 4'd3) || (r_self[i] && r_cnt[i] == 4'd2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_next <= n_next;
        end
    end

    assign o_res.valid        = r_v3;
    assign o_res.next_cells   = r_next;
    assign o_res.center_alive = r_next[lws_pkg::CENTER_IDX];

endmodule

`default_nettype wire

@@ rtl/lws_chk.sv @@
`default_nettype none

module lws_chk (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [lws_pkg::WIN_W-1:0]   i_next_cells,
    input wire logic                        i_center_alive,
    input wire logic                        i_cfg_ready
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_cells))
        else $error("result changed while stalled");

    // the center flag mirrors cell (2,2) of the result
    a_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_center_alive == i_next_cells[lws_pkg::CENTER_IDX])
        else $error("center_alive does not match next_cells");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result valid after reset");

    // ring writes are never back-pressured
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind life_window_step lws_chk u_lws_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_next_cells   (o_res.next_cells),
    .i_center_alive (o_res.center_alive),
    .i_cfg_ready    (i_cfg.ready)
);

`default_nettype wire

@@ tb/tb_life_window_step.sv @@
`timescale 1ns / 1ps

module tb_life_window_step;

    // cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // pipeline depth plus margin, used for the drain pauses
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PER_PHASE = 130;

    typedef struct packed {
        logic [lws_pkg::WIN_W-1:0]  cells;
        logic [lws_pkg::MODE_W-1:0] mode;
    } t_window_item;

    typedef struct packed {
        logic [lws_pkg::WIN_W-1:0] next_cells;
        logic                      center_alive;
    } t_generation;

    logic i_clk;
    logic i_rst_n;

    lws_in_if  win_if ();
    lws_out_if res_if ();
    lws_cfg_if cfg_if ();

    life_window_step i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (win_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // windows waiting to be sent, generations waiting to come back
    t_window_item pending_windows[$];
    t_generation  expected_gens[$];

    // local copy of the boundary ring register
    logic [lws_pkg::RING_W-1:0] ring_shadow;

    int mismatch_cnt;
    int idle_cycles;

    // sender burst shaping
    int burst_left;
    int gap_left;

    // receiver stall pattern: ready is low while stall_phase is below stall_width, stall_phase
    // wraps at stall_period, and the pattern is redrawn when pattern_left runs out
    int stall_period;
    int stall_width;
    int stall_phase;
    int pattern_left;

    // ------------------------------------------------------------------
    // Prediction: pad the window with the outside ring chosen by the mode,
    // then apply B3/S23 to each of the 25 window cells.
    // ------------------------------------------------------------------
    function automatic t_generation next_generation(
            input logic [lws_pkg::WIN_W-1:0]  cells,
            input logic [lws_pkg::MODE_W-1:0] mode,
            input logic [lws_pkg::RING_W-1:0] ring);
        logic        grid [0:lws_pkg::GSIDE-1][0:lws_pkg::GSIDE-1];
        logic        side_on;
        logic        cap_on;
        int          count;
        t_generation gen;
        side_on = (mode == lws_pkg::MODE_ALIVE) || (mode == lws_pkg::MODE_SIDES);
        cap_on  = (mode == lws_pkg::MODE_ALIVE) || (mode == lws_pkg::MODE_CAPS);
        for (int gy = 0; gy < lws_pkg::GSIDE; gy++) begin
            for (int gx = 0; gx < lws_pkg::GSIDE; gx++) begin
                if (gx >= 1 && gx <= lws_pkg::SIDE && gy >= 1 && gy <= lws_pkg::SIDE) begin
                    grid[gy][gx] = cells[lws_pkg::SIDE * (gy - 1) + (gx - 1)];
                end else if (mode >= lws_pkg::MODE_RING) begin
                    // modes five to seven also fall here
                    if (gy == 0)
                        grid[gy][gx] = ring[lws_pkg::RING_TOP + gx];
                    else if (gy == lws_pkg::GSIDE - 1)
                        grid[gy][gx] = ring[lws_pkg::RING_BOT + gx];
                    else if (gx == 0)
                        grid[gy][gx] = ring[lws_pkg::RING_SIDE + 2 * (gy - 1)];
                    else
                        grid[gy][gx] = ring[lws_pkg::RING_SIDE + 1 + 2 * (gy - 1)];
                end else if (gx == 0 || gx == lws_pkg::GSIDE - 1) begin
                    // side columns own the corners
                    grid[gy][gx] = side_on;
                end else begin
                    grid[gy][gx] = cap_on;
                end
            end
        end
        gen = '0;
        for (int y = 1; y <= lws_pkg::SIDE; y++) begin
            for (int x = 1; x <= lws_pkg::SIDE; x++) begin
                count = 0;
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            count += grid[y + dy][x + dx];
                if (count == 3 || (grid[y][x] && count == 2))
                    gen.next_cells[lws_pkg::SIDE * (y - 1) + (x - 1)] = 1'b1;
            end
        end
        gen.center_alive = gen.next_cells[lws_pkg::CENTER_IDX];
        return gen;
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Driver: on each accepted window transaction the expected generation
    // is computed with the ring as it stands; valid is held while the
    // block stalls and otherwise follows the burst/gap schedule.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            win_if.valid <= 1'b0;
        end else begin
            if (win_if.valid && win_if.ready) begin
                expected_gens.push_back(next_generation(pending_windows[0].cells,
                                                        pending_windows[0].mode,
                                                        ring_shadow));
                void'(pending_windows.pop_front());
            end
            if (win_if.valid && !win_if.ready) begin
                // transaction still pending, hold everything
            end else if (gap_left > 0) begin
                gap_left--;
                win_if.valid <= 1'b0;
            end else if (pending_windows.size() > 0) begin
                win_if.valid         <= 1'b1;
                win_if.window_cells  <= pending_windows[0].cells;
                win_if.boundary_mode <= pending_windows[0].mode;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // a quarter of the bursts are long and followed by no gap
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = $urandom_range(1, 7);
                    end
                end
            end else begin
                win_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest expected
    // generation, then advance the receiver stall pattern.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_generation exp_gen;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_gens.size() == 0) begin
                    $display("%0t: unexpected result next_cells=%h center_alive=%b",
                             $time, res_if.next_cells, res_if.center_alive);
                    mismatch_cnt++;
                end else begin
                    exp_gen = expected_gens.pop_front();
                    if (res_if.next_cells !== exp_gen.next_cells) begin
                        $display("%0t: next_cells expected %h actual %h",
                                 $time, exp_gen.next_cells, res_if.next_cells);
                        mismatch_cnt++;
                    end
                    if (res_if.center_alive !== exp_gen.center_alive) begin
                        $display("%0t: center_alive expected %b actual %b",
                                 $time, exp_gen.center_alive, res_if.center_alive);
                        mismatch_cnt++;
                    end
                end
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(30, 200);
                stall_period = $urandom_range(1, 9);
                // at least a third of the patterns never stall
                stall_width  = ($urandom_range(0, 2) == 0) ? 0
                               : $urandom_range(0, stall_period - 1);
                stall_phase  = 0;
            end else begin
                pattern_left--;
            end
            res_if.ready <= (stall_phase >= stall_width);
            stall_phase = (stall_phase + 1 >= stall_period) ? 0 : stall_phase + 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: counts cycles with no transaction on any channel.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((win_if.valid && win_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_window(input logic [lws_pkg::WIN_W-1:0]  cells,
                                input logic [lws_pkg::MODE_W-1:0] mode);
        t_window_item item;
        item.cells = cells;
        item.mode  = mode;
        pending_windows.push_back(item);
    endtask

    // all windows sent and all generations returned, pipeline drained
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_windows.size() != 0 || expected_gens.size() != 0 || win_if.valid);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ring(input logic [lws_pkg::RING_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        ring_shadow = value;
        cfg_if.valid <= 1'b0;
    endtask

    // random windows of mixed density; modes five to seven are rarer
    task automatic queue_random_windows(input int count);
        logic [31:0]                a;
        logic [31:0]                b;
        logic [31:0]                c;
        logic [lws_pkg::WIN_W-1:0]  cells;
        logic [lws_pkg::MODE_W-1:0] mode;
        int                         pick;
        @(negedge i_clk);
        for (int k = 0; k < count; k++) begin
            a = $urandom();
            b = $urandom();
            c = $urandom();
            case ($urandom_range(0, 3))
                0: cells = a[lws_pkg::WIN_W-1:0];
                1: cells = a[lws_pkg::WIN_W-1:0] & b[lws_pkg::WIN_W-1:0];
                2: cells = a[lws_pkg::WIN_W-1:0] | b[lws_pkg::WIN_W-1:0];
                default: cells = a[lws_pkg::WIN_W-1:0] & b[lws_pkg::WIN_W-1:0]
                                 & c[lws_pkg::WIN_W-1:0];
            endcase
            pick = $urandom_range(0, 12);
            mode = (pick < 10) ? lws_pkg::MODE_W'(pick / 2) : lws_pkg::MODE_W'(pick - 5);
            queue_window(cells, mode);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [lws_pkg::RING_W-1:0] ring_settings [7];
        i_rst_n              = 1'b0;
        win_if.valid         = 1'b0;
        win_if.window_cells  = '0;
        win_if.boundary_mode = lws_pkg::MODE_DEAD;
        res_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = '0;
        ring_shadow          = lws_pkg::RING_RESET;
        mismatch_cnt         = 0;
        idle_cycles          = 0;
        burst_left           = 0;
        gap_left             = 0;
        stall_period         = 1;
        stall_width          = 0;
        stall_phase          = 0;
        pattern_left         = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed windows, ring still at its reset value
        @(negedge i_clk);
        for (int m = 0; m < 8; m++)
            queue_window('0, lws_pkg::MODE_W'(m));      // empty window, every mode code
        for (int m = 0; m < 5; m++)
            queue_window('1, lws_pkg::MODE_W'(m));      // full window
        queue_window(25'h0003800, lws_pkg::MODE_DEAD);  // horizontal blinker
        queue_window(25'h0021080, lws_pkg::MODE_DEAD);  // vertical blinker
        queue_window(25'h0001C82, lws_pkg::MODE_DEAD);  // glider
        queue_window(25'h0000063, lws_pkg::MODE_ALIVE); // corner block
        queue_window(25'h1555555, lws_pkg::MODE_SIDES); // checkerboard
        queue_window(25'h0AAAAAA, lws_pkg::MODE_CAPS);  // inverse checkerboard
        queue_window(25'h0001000, lws_pkg::MODE_RING);  // lone center cell
        queue_window(25'h1100011, lws_pkg::MODE_RING);  // corners only
        queue_window(25'h1100011, lws_pkg::MODE_CAPS);
        queue_window(25'h0001000, 3'd7);
        queue_random_windows(RANDOM_PER_PHASE);
        wait_idle();

        ring_settings[0] = '0;
        ring_settings[1] = '1;
        ring_settings[2] = lws_pkg::RING_W'($urandom());
        ring_settings[3] = 24'h555555;
        ring_settings[4] = 24'hAAAAAA;
        ring_settings[5] = lws_pkg::RING_W'($urandom());
        ring_settings[6] = lws_pkg::RING_W'($urandom());

        // one phase per ring setting; ring only changes with the block idle
        foreach (ring_settings[p]) begin
            write_ring(ring_settings[p]);
            @(negedge i_clk);
            queue_window('0, lws_pkg::MODE_RING);
            queue_window('1, lws_pkg::MODE_RING);
            queue_random_windows(RANDOM_PER_PHASE);
            wait_idle();
        end

        if (mismatch_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/lws_pkg.sv
rtl/lws_if.sv
rtl/life_window_step.sv
rtl/lws_chk.sv
tb/tb_life_window_step.sv
